// File: design/ctsmc_pkg.sv
// ----------------------------------------------------------------------------
// ctsmc_pkg
// Shared types and constants for the call-trace stack memory checker.
// ----------------------------------------------------------------------------
package ctsmc_pkg;

	// parameter defaults
	localparam int NUM_PROCS_DEF   = 64;
	localparam int STACK_DEPTH_DEF = 32;
	localparam int SIZE_WIDTH_DEF  = 16;

	// fixed port widths
	localparam int ID_W      = 6;
	localparam int SIZE_IN_W = 16;
	localparam int MEM_W     = 21;
	localparam int POS_W     = 24;
	localparam int DEPTH_W   = 6;
	localparam int STATUS_W  = 3;

	localparam logic [MEM_W-1:0] MEM_MAX = '1;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	// trace item kinds
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_TRACE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_UNKNOWN    = 3'd1,
		ST_BAD_PARENT = 3'd2,
		ST_OVERFLOW   = 3'd3,
		ST_HALTED     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOAD,
		S_LOOK,
		S_TOP,
		S_POP,
		S_EMIT
	} state_t;

endpackage

// File: design/ctsmc_ram.sv
// ----------------------------------------------------------------------------
// ctsmc_ram
// Generic one-write, one-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ctsmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/call_trace_stack_memory_checker_core.sv
// ----------------------------------------------------------------------------
// call_trace_stack_memory_checker_core
// Follows a procedure-call trace and reports the memory held by the call
// stack. A load item sets a procedure's size. A trace item naming a procedure
// not on the stack pushes it and adds its size; naming one already on the
// stack unwinds every entry above it, subtracts their sizes and records the
// returned-to procedure as their parent, flagging a parent that disagrees
// with an earlier record. Any error in a trace item halts the checker until
// reset; an out-of-range load is reported but does not halt. Every input
// transfer yields exactly one result transfer. After reset a clearing pass
// wipes the procedure table; no input is taken during it. No new item is
// taken until the last one's result is emitted. A return reads and then
// writes the procedure table for each unwound entry.
// ----------------------------------------------------------------------------
module call_trace_stack_memory_checker_core
	import ctsmc_pkg::*;
#(
	parameter int NUM_PROCS   = NUM_PROCS_DEF,
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int SIZE_WIDTH  = SIZE_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// input channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                func,
	input  logic [ID_W-1:0]     proc_id,
	input  logic [SIZE_IN_W-1:0] proc_size,
	// result channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [MEM_W-1:0]    current_memory,
	output logic [MEM_W-1:0]    peak_memory,
	output logic [POS_W-1:0]    peak_position,
	output logic [DEPTH_W-1:0]  stack_depth,
	output logic [ID_W-1:0]     culprit_id
);

	localparam int PID_W  = $clog2(NUM_PROCS);
	localparam int SP_W   = $clog2(STACK_DEPTH + 1);
	localparam int STK_AW = $clog2(STACK_DEPTH);
	localparam int SUM_W  = ((SIZE_WIDTH > MEM_W) ? SIZE_WIDTH : MEM_W) + 1;

	// one procedure table entry: size, recorded parent and stack membership
	typedef struct packed {
		logic                  size_known;
		logic [SIZE_WIDTH-1:0] size;
		logic                  parent_known;
		logic [PID_W-1:0]      parent;
		logic                  on_stack;
	} proc_entry_t;

	localparam int PE_W = $bits(proc_entry_t);

	// control state
	state_t              state_q, state_d;
	logic [PID_W-1:0]    clr_q;
	logic [SP_W-1:0]     sp_q, sp_d;
	logic [MEM_W-1:0]    mem_q, mem_d;
	logic [MEM_W-1:0]    max_q;
	logic [POS_W-1:0]    maxpos_q;
	logic [POS_W-1:0]    pos_q;
	logic                halted_q;
	logic                out_valid_q;

	// item registers
	logic [ID_W-1:0]       id_q;
	logic [PID_W-1:0]      idx_q;
	logic [SIZE_WIDTH-1:0] size_q;
	logic [PID_W-1:0]      top_q;
	status_t               res_status_q, res_status_d;
	logic [ID_W-1:0]       res_culprit_q, res_culprit_d;

	// result registers
	status_t            status_out_q;
	logic [MEM_W-1:0]   cur_out_q;
	logic [MEM_W-1:0]   peak_out_q;
	logic [POS_W-1:0]   peakpos_out_q;
	logic [DEPTH_W-1:0] depth_out_q;
	logic [ID_W-1:0]    culprit_out_q;

	// memory ports
	logic              pt_we, pt_re;
	logic [PID_W-1:0]  pt_waddr, pt_raddr;
	proc_entry_t       pt_wdata, pt_rd;
	logic [PE_W-1:0]   pt_rdata;
	logic              st_we, st_re;
	logic [STK_AW-1:0] st_waddr, st_raddr;
	logic [PID_W-1:0]  st_wdata, st_rdata;

	// per-cycle decisions
	logic             accept;
	logic             id_in_range;
	logic [PID_W-1:0] idx_in;
	logic             clr_last;
	logic             top_is_id;
	logic             stack_full;
	logic             parent_bad;
	logic             out_free;
	logic             finish_ok;
	logic             halt_set;
	logic             emit;
	logic             load_item;
	logic             top_ld;
	logic [SUM_W-1:0] push_sum;
	logic [SUM_W-1:0] pop_size;

	assign accept      = in_valid && in_ready;
	assign id_in_range = 32'(proc_id) < NUM_PROCS;
	assign idx_in      = PID_W'(proc_id);
	assign clr_last    = clr_q == PID_W'(NUM_PROCS - 1);
	assign pt_rd       = proc_entry_t'(pt_rdata);
	assign top_is_id   = st_rdata == idx_q;
	assign stack_full  = sp_q >= SP_W'(STACK_DEPTH);
	assign parent_bad  = pt_rd.parent_known && (pt_rd.parent != idx_q);
	assign out_free    = !out_valid_q || out_ready;
	assign push_sum    = SUM_W'(mem_q) + SUM_W'(pt_rd.size);
	assign pop_size    = pt_rd.size_known ? SUM_W'(pt_rd.size) : '0;

	assign in_ready = (state_q == S_IDLE);
	assign emit     = (state_q == S_EMIT) && out_free;

	// procedure table: size, parent and on-stack flag per procedure
	ctsmc_ram #(
		.WIDTH (PE_W),
		.DEPTH (NUM_PROCS)
	) u_proc_ram (
		.clk   (clk),
		.we    (pt_we),
		.waddr (pt_waddr),
		.wdata (pt_wdata),
		.re    (pt_re),
		.raddr (pt_raddr),
		.rdata (pt_rdata)
	);

	// call stack of procedure indexes
	ctsmc_ram #(
		.WIDTH (PID_W),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	// ---------------------------------------------------------------- next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					if (func == FUNC_LOAD) begin
						state_d = id_in_range ? S_LOAD : S_EMIT;
					end else begin
						state_d = (halted_q || !id_in_range) ? S_EMIT : S_LOOK;
					end
				end
			end
			S_LOAD: state_d = S_EMIT;
			S_LOOK: begin
				if (pt_rd.on_stack && !top_is_id) state_d = S_POP;
				else                              state_d = S_EMIT;
			end
			S_TOP: state_d = top_is_id ? S_EMIT : S_POP;
			S_POP: state_d = parent_bad ? S_EMIT : S_TOP;
			S_EMIT: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ---------------------------------------------------------------- datapath control
	always_comb begin
		pt_we         = 1'b0;
		pt_waddr      = idx_q;
		pt_wdata      = pt_rd;
		pt_re         = 1'b0;
		pt_raddr      = idx_in;
		st_we         = 1'b0;
		st_waddr      = STK_AW'(sp_q);
		st_wdata      = idx_q;
		st_re         = 1'b0;
		st_raddr      = STK_AW'(sp_q - 1'b1);
		sp_d          = sp_q;
		mem_d         = mem_q;
		res_status_d  = res_status_q;
		res_culprit_d = res_culprit_q;
		finish_ok     = 1'b0;
		halt_set      = 1'b0;
		load_item     = 1'b0;
		top_ld        = 1'b0;

		unique case (state_q)
			S_CLEAR: begin
				pt_we    = 1'b1;
				pt_waddr = clr_q;
				pt_wdata = '0;
			end
			S_IDLE: begin
				if (accept) begin
					load_item     = 1'b1;
					res_status_d  = ST_OK;
					res_culprit_d = '0;
					if (func == FUNC_LOAD) begin
						if (id_in_range) begin
							// read the entry so its stack membership survives the load
							pt_re = 1'b1;
						end else begin
							res_status_d  = ST_UNKNOWN;
							res_culprit_d = proc_id;
						end
					end else if (halted_q) begin
						res_status_d = ST_HALTED;
					end else if (!id_in_range) begin
						res_status_d  = ST_UNKNOWN;
						res_culprit_d = proc_id;
						halt_set      = 1'b1;
					end else begin
						// fetch the entry and the stack top together
						pt_re = 1'b1;
						st_re = 1'b1;
					end
				end
			end
			S_LOAD: begin
				pt_we                 = 1'b1;
				pt_wdata.size_known   = 1'b1;
				pt_wdata.size         = size_q;
				pt_wdata.parent_known = 1'b0;
				res_status_d          = halted_q ? ST_HALTED : ST_OK;
			end
			S_LOOK: begin
				if (pt_rd.on_stack) begin
					if (top_is_id) begin
						finish_ok = 1'b1;
					end else begin
						// start unwinding: fetch the top entry and the one below it
						top_ld   = 1'b1;
						pt_re    = 1'b1;
						pt_raddr = st_rdata;
						st_re    = 1'b1;
						st_raddr = STK_AW'(sp_q - SP_W'(2));
					end
				end else if (stack_full) begin
					res_status_d  = ST_OVERFLOW;
					res_culprit_d = id_q;
					halt_set      = 1'b1;
				end else if (!pt_rd.size_known) begin
					res_status_d  = ST_UNKNOWN;
					res_culprit_d = id_q;
					halt_set      = 1'b1;
				end else begin
					// push the call
					st_we             = 1'b1;
					pt_we             = 1'b1;
					pt_wdata.on_stack = 1'b1;
					sp_d              = sp_q + 1'b1;
					mem_d             = (push_sum > SUM_W'(MEM_MAX)) ? MEM_MAX
					                                                 : MEM_W'(push_sum);
					finish_ok         = 1'b1;
				end
			end
			S_TOP: begin
				if (top_is_id) begin
					finish_ok = 1'b1;
				end else begin
					top_ld   = 1'b1;
					pt_re    = 1'b1;
					pt_raddr = st_rdata;
					st_re    = 1'b1;
					st_raddr = STK_AW'(sp_q - SP_W'(2));
				end
			end
			S_POP: begin
				if (parent_bad) begin
					res_status_d  = ST_BAD_PARENT;
					res_culprit_d = ID_W'(top_q);
					halt_set      = 1'b1;
				end else begin
					// drop the top entry and record its parent
					pt_we                 = 1'b1;
					pt_waddr              = top_q;
					pt_wdata.parent_known = 1'b1;
					pt_wdata.parent       = idx_q;
					pt_wdata.on_stack     = 1'b0;
					sp_d                  = sp_q - 1'b1;
					mem_d                 = (SUM_W'(mem_q) > pop_size)
					                        ? MEM_W'(SUM_W'(mem_q) - pop_size) : '0;
				end
			end
			S_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	// ---------------------------------------------------------------- control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			sp_q        <= '0;
			mem_q       <= '0;
			max_q       <= '0;
			maxpos_q    <= '0;
			pos_q       <= '0;
			halted_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sp_q    <= sp_d;
			mem_q   <= mem_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			// count trace items while running, saturate at the top
			if (accept && func == FUNC_TRACE && !halted_q && pos_q != POS_MAX) begin
				pos_q <= pos_q + 1'b1;
			end
			// peak moves only when strictly exceeded
			if (finish_ok && max_q < mem_d) begin
				max_q    <= mem_d;
				maxpos_q <= pos_q;
			end
			if (halt_set) begin
				halted_q <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- payload registers
	always_ff @(posedge clk) begin
		res_status_q  <= res_status_d;
		res_culprit_q <= res_culprit_d;
		if (load_item) begin
			id_q   <= proc_id;
			idx_q  <= idx_in;
			size_q <= SIZE_WIDTH'(proc_size);
		end
		if (top_ld) begin
			top_q <= st_rdata;
		end
		if (emit) begin
			status_out_q  <= res_status_q;
			cur_out_q     <= mem_q;
			peak_out_q    <= max_q;
			peakpos_out_q <= maxpos_q;
			depth_out_q   <= DEPTH_W'(sp_q);
			culprit_out_q <= res_culprit_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_out_q;
	assign current_memory = cur_out_q;
	assign peak_memory    = peak_out_q;
	assign peak_position  = peakpos_out_q;
	assign stack_depth    = depth_out_q;
	assign culprit_id     = culprit_out_q;

	// ---------------------------------------------------------------- assertions
`ifndef SYNTHESIS
	// the stack pointer never runs past the stack
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("stack pointer beyond stack depth");

	// an error halts the checker for good
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt flag cleared without reset");

	// pops only shrink memory and pushes update the peak, so the peak bounds it
	a_peak_bound: assert property (@(posedge clk) disable iff (!arst_n)
		max_q >= mem_q)
		else $error("current memory above peak");
`endif

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the call-trace stack memory checker. A short table
// of loads, calls and returns opens the run. Random traces follow, built from
// the tracked stack so that they stay free of errors, with a climb to the
// memory ceiling. One error picked at random closes the run, then halted
// traffic. Every result is compared with a behavioral copy of the checker.
// ----------------------------------------------------------------------------
module testbench;
	import ctsmc_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int PROBE_COUNT = 20;
	localparam int RANDOM_ITEMS = 500;
	// never loaded before the last phase, so a call to it is always unknown
	localparam logic [ID_W-1:0] NEVER_LOADED = 6'd62;

	typedef struct packed {
		status_t            st;
		logic [MEM_W-1:0]   mem;
		logic [MEM_W-1:0]   peak;
		logic [POS_W-1:0]   pos;
		logic [DEPTH_W-1:0] depth;
		logic [ID_W-1:0]    culprit;
	} usage_t;

	// one directed row; pin marks rows whose status, memory and depth are typed in
	typedef struct packed {
		logic               f;
		logic [ID_W-1:0]    id;
		logic [SIZE_IN_W-1:0] sz;
		logic               pin;
		status_t            st;
		logic [MEM_W-1:0]   mem;
		logic [DEPTH_W-1:0] dep;
	} probe_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 func;
	logic [ID_W-1:0]      proc_id;
	logic [SIZE_IN_W-1:0] proc_size;
	logic                 out_valid;
	logic                 out_ready;
	logic [STATUS_W-1:0]  status;
	logic [MEM_W-1:0]     current_memory;
	logic [MEM_W-1:0]     peak_memory;
	logic [POS_W-1:0]     peak_position;
	logic [DEPTH_W-1:0]   stack_depth;
	logic [ID_W-1:0]      culprit_id;

	call_trace_stack_memory_checker_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.proc_id        (proc_id),
		.proc_size      (proc_size),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.current_memory (current_memory),
		.peak_memory    (peak_memory),
		.peak_position  (peak_position),
		.stack_depth    (stack_depth),
		.culprit_id     (culprit_id)
	);

	// shadow of the checker state
	logic [SIZE_IN_W-1:0] size_of   [NUM_PROCS_DEF];
	bit                   size_set  [NUM_PROCS_DEF];
	logic [ID_W-1:0]      parent_of [NUM_PROCS_DEF];
	bit                   parent_set[NUM_PROCS_DEF];
	bit                   stacked   [NUM_PROCS_DEF];
	logic [ID_W-1:0]      frames    [STACK_DEPTH_DEF];
	int                   depth = 0;
	int unsigned          mem = 0;
	int unsigned          peak = 0;
	logic [POS_W-1:0]     peak_at = '0;
	logic [POS_W-1:0]     trace_pos = '0;
	bit                   halted = 0;

	usage_t expected_usage[$];
	usage_t head;
	probe_t probes[PROBE_COUNT];
	int     mismatches = 0;
	int     quiet = 0;
	bit     calm = 0;

	// Advance the shadow by one item and return the result it must produce.
	function automatic usage_t follow_trace(logic f, logic [ID_W-1:0] id,
			logic [SIZE_IN_W-1:0] sz);
		usage_t r;
		logic [ID_W-1:0] top;
		int unsigned sub;
		bit fault;
		bit done;
		r.st = ST_OK;
		r.culprit = '0;
		fault = 0;
		done = 0;
		if (f == FUNC_LOAD) begin
			// a fresh definition forgets the recorded parent
			size_of[id] = sz;
			size_set[id] = 1;
			parent_set[id] = 0;
			if (halted)
				r.st = ST_HALTED;
		end else if (halted) begin
			r.st = ST_HALTED;
		end else begin
			if (trace_pos < POS_MAX)
				trace_pos++;
			if (stacked[id]) begin
				// return: unwind down to the named procedure
				while (depth > 0 && !done) begin
					top = frames[depth - 1];
					if (top == id) begin
						done = 1;
					end else if (parent_set[top] && parent_of[top] != id) begin
						r.st = ST_BAD_PARENT;
						r.culprit = top;
						fault = 1;
						done = 1;
					end else begin
						sub = size_set[top] ? size_of[top] : 0;
						mem = (mem > sub) ? mem - sub : 0;
						parent_of[top] = id;
						parent_set[top] = 1;
						stacked[top] = 0;
						depth--;
					end
				end
			end else if (depth >= STACK_DEPTH_DEF) begin
				r.st = ST_OVERFLOW;
				r.culprit = id;
				fault = 1;
			end else if (!size_set[id]) begin
				r.st = ST_UNKNOWN;
				r.culprit = id;
				fault = 1;
			end else begin
				frames[depth] = id;
				depth++;
				stacked[id] = 1;
				mem = mem + size_of[id];
				if (mem > MEM_MAX)
					mem = MEM_MAX;
			end
			if (fault) begin
				halted = 1;
			end else if (peak < mem) begin
				// only a strict rise moves the peak
				peak = mem;
				peak_at = trace_pos;
			end
		end
		r.mem = MEM_W'(mem);
		r.peak = MEM_W'(peak);
		r.pos = peak_at;
		r.depth = DEPTH_W'(depth);
		return r;
	endfunction

	// True when a trace item naming id would pass without an error.
	function automatic bit trace_is_safe(logic [ID_W-1:0] id);
		int k;
		bit safe;
		safe = 1;
		if (stacked[id]) begin
			for (k = depth - 1; k >= 0 && frames[k] != id; k--)
				if (parent_set[frames[k]] && parent_of[frames[k]] != id)
					safe = 0;
		end else begin
			safe = (depth < STACK_DEPTH_DEF) && size_set[id];
		end
		return safe;
	endfunction

	function automatic logic [ID_W-1:0] pick_id();
		logic [ID_W-1:0] id;
		do id = ID_W'($urandom_range(0, NUM_PROCS_DEF - 1)); while (id == NEVER_LOADED);
		return id;
	endfunction

	function automatic logic [ID_W-1:0] fresh_id();
		logic [ID_W-1:0] id;
		do id = pick_id(); while (stacked[id]);
		return id;
	endfunction

	function automatic logic [SIZE_IN_W-1:0] pick_size();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return SIZE_IN_W'($urandom_range(1, 255));
			default: return SIZE_IN_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [SIZE_IN_W-1:0] any_size();
		return SIZE_IN_W'($urandom_range(0, 65535));
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		$display("mismatch on %s: got %0d, want %0d", what, got, want);
	endtask

	// Present one item and hold it until the transfer; idle first at random.
	task automatic drive_item(logic f, logic [ID_W-1:0] id, logic [SIZE_IN_W-1:0] sz);
		if (!calm)
			while ($urandom_range(0, 99) < 31) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid <= 1'b1;
		func <= f;
		proc_id <= id;
		proc_size <= sz;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_item(logic f, logic [ID_W-1:0] id, logic [SIZE_IN_W-1:0] sz);
		expected_usage.push_back(follow_trace(f, id, sz));
		drive_item(f, id, sz);
	endtask

	// Hold the input side until every outstanding result has come back.
	task automatic settle_results();
		in_valid <= 1'b0;
		while (expected_usage.size() != 0)
			@(posedge clk);
	endtask

	// Drop the top frame cleanly: forget its parent, then return below it.
	task automatic pop_top();
		send_item(FUNC_LOAD, frames[depth - 1], pick_size());
		send_item(FUNC_TRACE, frames[depth - 2], any_size());
	endtask

	task automatic fill_stack();
		logic [ID_W-1:0] id;
		while (depth < STACK_DEPTH_DEF) begin
			id = fresh_id();
			send_item(FUNC_LOAD, id, '1);
			send_item(FUNC_TRACE, id, any_size());
		end
	endtask

	// Mostly well-formed calls and returns; fall back to a load when the
	// drawn trace entry would trip an error.
	task automatic send_random_item();
		logic [ID_W-1:0] id;
		int tries;
		bit ok;
		if ($urandom_range(0, 99) < 30) begin
			if (depth > 0 && $urandom_range(0, 2) == 0)
				id = frames[$urandom_range(0, depth - 1)];
			else
				id = pick_id();
			send_item(FUNC_LOAD, id, pick_size());
		end else begin
			ok = 0;
			for (tries = 0; tries < 8 && !ok; tries++) begin
				if (depth > 0 && $urandom_range(0, 1) == 1)
					id = frames[$urandom_range(0, depth - 1)];
				else
					id = pick_id();
				ok = trace_is_safe(id);
			end
			if (ok)
				send_item(FUNC_TRACE, id, any_size());
			else if (stacked[id])
				send_item(FUNC_LOAD, frames[depth - 1], pick_size());
			else
				send_item(FUNC_LOAD, id, pick_size());
		end
	endtask

	// Fill the stack with full-size frames, swap the top for fresh full-size
	// ones until the running sum clamps at its ceiling, then pop to four frames.
	task automatic climb_to_ceiling();
		logic [ID_W-1:0] id;
		int k;
		fill_stack();
		for (k = 0; k < 40 && mem < MEM_MAX; k++) begin
			send_item(FUNC_LOAD, frames[depth - 1], '0);
			send_item(FUNC_TRACE, frames[depth - 2], any_size());
			id = fresh_id();
			send_item(FUNC_LOAD, id, '1);
			send_item(FUNC_TRACE, id, any_size());
		end
		while (depth > 4)
			pop_top();
	endtask

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Check each result transfer against the oldest expectation, then
	// drop ready at random except during the calm stretch.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_usage.size() == 0) begin
				report_mismatch("result with nothing outstanding, status", status, 0);
			end else begin
				head = expected_usage.pop_front();
				if (status !== head.st)
					report_mismatch("status", status, head.st);
				if (current_memory !== head.mem)
					report_mismatch("current_memory", current_memory, head.mem);
				if (peak_memory !== head.peak)
					report_mismatch("peak_memory", peak_memory, head.peak);
				if (peak_position !== head.pos)
					report_mismatch("peak_position", peak_position, head.pos);
				if (stack_depth !== head.depth)
					report_mismatch("stack_depth", stack_depth, head.depth);
				if (culprit_id !== head.culprit)
					report_mismatch("culprit_id", culprit_id, head.culprit);
			end
		end
		out_ready <= calm || ($urandom_range(0, 99) >= 31);
	end

	// Watchdog: end the run once no transfer has happened for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		usage_t exp;
		int n;
		logic [ID_W-1:0] a, b, c;

		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_LOAD;
		proc_id = '0;
		proc_size = '0;
		out_ready = 1'b0;

		// bottom frame 63 has size zero so later returns can floor at zero
		probes[0]  = '{FUNC_LOAD,  6'd63, 16'h0000, 1'b1, ST_OK, 21'd0,     6'd0};
		probes[1]  = '{FUNC_LOAD,  6'd0,  16'hFFFF, 1'b1, ST_OK, 21'd0,     6'd0};
		probes[2]  = '{FUNC_LOAD,  6'd1,  16'd100,  1'b0, ST_OK, 21'd0,     6'd0};
		probes[3]  = '{FUNC_TRACE, 6'd63, 16'hFFFF, 1'b1, ST_OK, 21'd0,     6'd1};
		probes[4]  = '{FUNC_TRACE, 6'd0,  16'h0000, 1'b1, ST_OK, 21'd65535, 6'd2};
		probes[5]  = '{FUNC_TRACE, 6'd1,  16'h0000, 1'b1, ST_OK, 21'd65635, 6'd3};
		// return to the bottom: pops two, both learn 63 as their parent
		probes[6]  = '{FUNC_TRACE, 6'd63, 16'h0000, 1'b1, ST_OK, 21'd0,     6'd1};
		// same chain again: peak only ties, its position must hold
		probes[7]  = '{FUNC_TRACE, 6'd0,  16'h0000, 1'b0, ST_OK, 21'd0,     6'd0};
		probes[8]  = '{FUNC_TRACE, 6'd1,  16'h0000, 1'b0, ST_OK, 21'd0,     6'd0};
		probes[9]  = '{FUNC_TRACE, 6'd63, 16'h0000, 1'b0, ST_OK, 21'd0,     6'd0};
		// reload while on the stack, so the pop subtracts more than was added
		probes[10] = '{FUNC_LOAD,  6'd1,  16'd10,   1'b0, ST_OK, 21'd0,     6'd0};
		probes[11] = '{FUNC_TRACE, 6'd1,  16'h0000, 1'b0, ST_OK, 21'd0,     6'd0};
		probes[12] = '{FUNC_LOAD,  6'd1,  16'hFFFF, 1'b0, ST_OK, 21'd0,     6'd0};
		probes[13] = '{FUNC_TRACE, 6'd63, 16'h0000, 1'b1, ST_OK, 21'd0,     6'd1};
		// alternating bit patterns on id and size
		probes[14] = '{FUNC_LOAD,  6'd5,  16'hAAAA, 1'b0, ST_OK, 21'd0,     6'd0};
		probes[15] = '{FUNC_LOAD,  6'd42, 16'h5555, 1'b0, ST_OK, 21'd0,     6'd0};
		probes[16] = '{FUNC_TRACE, 6'd5,  16'h5555, 1'b0, ST_OK, 21'd0,     6'd0};
		probes[17] = '{FUNC_TRACE, 6'd42, 16'hAAAA, 1'b0, ST_OK, 21'd0,     6'd0};
		probes[18] = '{FUNC_TRACE, 6'd5,  16'h0000, 1'b0, ST_OK, 21'd0,     6'd0};
		probes[19] = '{FUNC_TRACE, 6'd63, 16'h0000, 1'b0, ST_OK, 21'd0,     6'd0};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed rows: pinned fields replace the prediction
		for (n = 0; n < PROBE_COUNT; n++) begin
			exp = follow_trace(probes[n].f, probes[n].id, probes[n].sz);
			if (probes[n].pin) begin
				exp.st = probes[n].st;
				exp.mem = probes[n].mem;
				exp.depth = probes[n].dep;
			end
			expected_usage.push_back(exp);
			drive_item(probes[n].f, probes[n].id, probes[n].sz);
		end

		// random traffic with one climb, one full drain and a calm stretch
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 200)
				climb_to_ceiling();
			if (n == 300)
				settle_results();
			calm = (n >= 350 && n < 450);
			send_random_item();
		end
		calm = 0;
		settle_results();

		// close with one error of a kind picked at random; it halts for good
		case ($urandom_range(0, 2))
			0: begin
				fill_stack();
				a = fresh_id();
				send_item(FUNC_LOAD, a, pick_size());
				send_item(FUNC_TRACE, a, any_size());
			end
			1: begin
				while (depth > 28)
					pop_top();
				send_item(FUNC_TRACE, NEVER_LOADED, any_size());
			end
			default: begin
				// teach b that a is its parent, then return from b to c
				while (depth > 28)
					pop_top();
				a = fresh_id();
				do b = fresh_id(); while (b == a);
				do c = fresh_id(); while (c == a || c == b);
				send_item(FUNC_LOAD, a, pick_size());
				send_item(FUNC_LOAD, b, pick_size());
				send_item(FUNC_LOAD, c, pick_size());
				send_item(FUNC_TRACE, a, '0);
				send_item(FUNC_TRACE, b, '0);
				send_item(FUNC_TRACE, a, '0);
				send_item(FUNC_TRACE, c, '0);
				send_item(FUNC_TRACE, b, '0);
				send_item(FUNC_TRACE, c, '0);
			end
		endcase

		// halted: loads and traces of any id
		repeat (12)
			send_item(1'($urandom_range(0, 1)), ID_W'($urandom_range(0, NUM_PROCS_DEF - 1)),
				any_size());

		settle_results();
		repeat (70) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
